FILE: rtl/core/websocket_frame_deframer_unit_defines.svh
// Assertion macros for the WebSocket frame deframer.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// cond implies expr in the same cycle
`define WSFD_ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("wsfd: same-cycle check failed");

// cond implies expr in the next cycle
`define WSFD_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("wsfd: next-cycle check failed");

`endif

FILE: rtl/core/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
package wsfd_pkg;

	localparam logic [6:0] LEN_EXT64   = 7'd127;
	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] EXT16_BYTES = 4'd2;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [3:0] {
		PH_HDR1 = 4'b0001,
		PH_HDR2 = 4'b0010,
		PH_EXT  = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [63:0] message_length;
		logic [3:0]  message_opcode;
		logic        message_last;
		logic        has_byte;
		logic [7:0]  payload_byte;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

FILE: rtl/core/wsfd_parser.sv
// Front part: header parser and payload classifier, one byte per cycle while accept is high.
// Depends on wsfd_pkg.
module wsfd_parser
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	output logic        push,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  ext_left_q, ext_left_d;
	logic [63:0] frame_rem_q, frame_rem_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        taken_q, taken_d;
	logic [63:0] total_q, total_d;

	logic        hdr_fire;
	logic [63:0] hdr_len;
	logic [64:0] sum;
	logic [63:0] total_sat;
	logic [63:0] ext_len;
	logic [3:0]  ext_cnt;
	logic [63:0] rem_dec;

	assign sum       = {1'b0, total_q} + {1'b0, hdr_len};
	assign total_sat = sum[64] ? {64{1'b1}} : sum[63:0];
	assign ext_len   = {frame_rem_q[55:0], in_byte};
	assign ext_cnt   = ext_left_q - {3'd0, (ext_left_q != 4'd0)};
	assign rem_dec   = frame_rem_q - 64'd1;

	always_comb begin
		phase_d     = phase_q;
		ext_left_d  = ext_left_q;
		frame_rem_d = frame_rem_q;
		fin_d       = fin_q;
		opcode_d    = opcode_q;
		taken_d     = taken_q;
		total_d     = total_q;
		hdr_fire    = 1'b0;
		hdr_len     = 64'd0;
		push        = 1'b0;
		res         = '0;
		res.message_opcode = opcode_q;
		res.message_length = total_q;

		unique case (phase_q)
			PH_HDR1: begin
				fin_d = in_byte[7];
				if (!taken_q) begin
					opcode_d = in_byte[3:0];
					taken_d  = 1'b1;
				end
				phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				frame_rem_d = 64'd0;
				if (in_byte[6:0] == LEN_EXT64) begin
					ext_left_d = EXT64_BYTES;
					phase_d    = PH_EXT;
				end else if (in_byte[6:0] == LEN_EXT16) begin
					ext_left_d = EXT16_BYTES;
					phase_d    = PH_EXT;
				end else begin
					hdr_fire = 1'b1;
					hdr_len  = {57'd0, in_byte[6:0]};
				end
			end
			PH_EXT: begin
				frame_rem_d = ext_len;
				ext_left_d  = ext_cnt;
				if (ext_cnt == 4'd0) begin
					hdr_fire = 1'b1;
					hdr_len  = ext_len;
				end
			end
			PH_DATA: begin
				frame_rem_d      = rem_dec;
				push             = accept;
				res.payload_byte = in_byte;
				res.has_byte     = 1'b1;
				res.message_last = (rem_dec == 64'd0) && fin_q;
				if (rem_dec == 64'd0) begin
					phase_d = PH_HDR1;
					if (fin_q) begin
						taken_d = 1'b0;
						total_d = 64'd0;
					end
				end
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase

		// frame length known: add it up, then payload or next header; an empty final frame pushes an end word
		if (hdr_fire) begin
			frame_rem_d = hdr_len;
			total_d     = total_sat;
			if (hdr_len != 64'd0) begin
				phase_d = PH_DATA;
			end else begin
				phase_d = PH_HDR1;
				if (fin_q) begin
					push               = accept;
					res.message_last   = 1'b1;
					res.message_length = total_sat;
					taken_d            = 1'b0;
					total_d            = 64'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR1;
			ext_left_q  <= 4'd0;
			frame_rem_q <= 64'd0;
			fin_q       <= 1'b0;
			opcode_q    <= 4'd0;
			taken_q     <= 1'b0;
			total_q     <= 64'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			ext_left_q  <= ext_left_d;
			frame_rem_q <= frame_rem_d;
			fin_q       <= fin_d;
			opcode_q    <= opcode_d;
			taken_q     <= taken_d;
			total_q     <= total_d;
		end
	end

endmodule

FILE: rtl/core/wsfd_queue.sv
// Short result queue between parser and output stage.
// Depends on wsfd_pkg.
module wsfd_queue
	import wsfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  result_t     push_res,
	input  logic        pop,
	output result_t     head,
	output queue_stat_t stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	result_t       mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/wsfd_out.sv
// Back part: output register that presents queued results to the receiver.
// Depends on wsfd_pkg.
module wsfd_out
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  result_t     head,
	input  queue_stat_t stat,
	output logic        pop,
	input  logic        out_ready,
	output logic        out_valid,
	output result_t     out_res
);

	logic    valid_q;
	result_t res_q;

	// load whenever the register is empty or being taken
	assign pop       = !stat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head;
		end
	end

endmodule

FILE: rtl/core/websocket_frame_deframer_unit.sv
// WebSocket frame deframer, receive side.
// Input: s_axis carries the received frame stream, one byte per word, in
// s_axis_tdata[7:0]. Header and extended-length bytes give no output word;
// each payload byte gives one, and a final frame of length zero gives one
// empty end word (tuser bit 0 low, tlast high).
// Output: m_axis carries the payload byte and the message length summed so
// far in tdata, the message opcode and a has-byte flag in tuser, and tlast
// on the last word of a message. Mask bits are ignored; no mask key is read.
// Throughput: one input byte per cycle while the queue is not full, header and
// payload bytes alike.
// Path: the parser writes an output word into the queue as its byte is accepted;
// the output register then loads it from the queue head when the register is
// empty or being taken.
// Stall: when m_axis_tready is low the output register holds and the queue
// fills; s_axis_tready drops only once QUEUE_DEPTH words are waiting.
// Reset: arst_n clears parser state to wait for a first header byte and
// empties the queue and output register; no clearing pass is needed.
// Depends on wsfd_pkg, wsfd_parser, wsfd_queue, wsfd_out and the defines header.
`include "websocket_frame_deframer_unit_defines.svh"

module websocket_frame_deframer_unit
	import wsfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [7:0] payload_byte, [71:8] message_length
	output logic [4:0]  m_axis_tuser,  // [0] has_byte, [4:1] message_opcode
	output logic        m_axis_tlast   // message_last
);

	logic        accept;
	logic        q_push;
	logic        q_pop;
	result_t     parse_res;
	result_t     q_head;
	result_t     out_res;
	queue_stat_t q_stat;

	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_axis_tdata),
		.push    (q_push),
		.res     (parse_res)
	);

	wsfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_res (parse_res),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	wsfd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.stat      (q_stat),
		.pop       (q_pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.message_length, out_res.payload_byte};
	assign m_axis_tuser = {out_res.message_opcode, out_res.has_byte};
	assign m_axis_tlast = out_res.message_last;

	`WSFD_ASSERT_IMPLY(a_push_has_room, q_push, !q_stat.full)
	`WSFD_ASSERT_IMPLY(a_empty_word_ends_msg, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
	`WSFD_ASSERT_NEXT(a_pop_fills_output, q_pop, m_axis_tvalid)

endmodule

FILE: tb/tb_websocket_frame_deframer_unit.sv
// Self-checking testbench for the WebSocket frame deframer: drives framed byte streams
// and checks every output word against an in-bench parser of the same framing.
// Depends on wsfd_pkg and websocket_frame_deframer_unit.
module tb_websocket_frame_deframer_unit
	import wsfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic [7:0] data;
		bit         hold_off;
	} rx_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [4:0]  m_axis_tuser;
	logic        m_axis_tlast;

	rx_word_t rx_bytes[$];
	result_t  payload_due[$];

	// parser state mirrored from the block
	phase_t      rx_phase = PH_HDR1;
	logic [3:0]  ext_left = '0;
	logic [63:0] frame_left = '0;
	logic        frame_fin = 1'b0;
	logic [3:0]  msg_opcode = '0;
	logic        opcode_held = 1'b0;
	logic [63:0] msg_length = '0;

	int  errors = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  word_taken = 1'b0;
	bit  quiet = 1'b0;

	websocket_frame_deframer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 65)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void push_byte(input logic [7:0] d, input bit hold);
		rx_word_t w;
		w.data = d;
		w.hold_off = hold;
		rx_bytes.push_back(w);
	endfunction

	// kind: 0 seven-bit length, 1 16-bit extended, 2 64-bit extended
	function automatic void add_frame(input bit fin, input logic [3:0] opc,
			input logic [2:0] rsv, input bit mask, input int kind,
			input logic [63:0] flen, input int nbytes, input bit hold);
		push_byte({fin, rsv, opc}, hold);
		case (kind)
			0: begin
				push_byte({mask, flen[6:0]}, 1'b0);
			end
			1: begin
				push_byte({mask, LEN_EXT16}, 1'b0);
				push_byte(flen[15:8], 1'b0);
				push_byte(flen[7:0], 1'b0);
			end
			default: begin
				push_byte({mask, LEN_EXT64}, 1'b0);
				for (int i = 7; i >= 0; i--)
					push_byte(flen[i*8 +: 8], 1'b0);
			end
		endcase
		repeat (nbytes)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endfunction

	function automatic void expect_word(input logic [7:0] d, input logic has,
			input logic last);
		result_t r;
		r.payload_byte   = d;
		r.has_byte       = has;
		r.message_last   = last;
		r.message_opcode = msg_opcode;
		r.message_length = msg_length;
		payload_due.push_back(r);
	endfunction

	function automatic void end_message();
		opcode_held = 1'b0;
		msg_length = '0;
	endfunction

	// frame length known: add it to the message, then payload or next header; an empty final frame expects an end word
	function automatic void close_header();
		logic [64:0] sum;
		sum = {1'b0, msg_length} + {1'b0, frame_left};
		msg_length = sum[64] ? '1 : sum[63:0];
		if (frame_left != 0) begin
			rx_phase = PH_DATA;
		end else begin
			rx_phase = PH_HDR1;
			if (frame_fin) begin
				expect_word(8'h00, 1'b0, 1'b1);
				end_message();
			end
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		case (rx_phase)
			PH_HDR1: begin
				frame_fin = b[7];
				if (!opcode_held) begin
					msg_opcode = b[3:0];
					opcode_held = 1'b1;
				end
				rx_phase = PH_HDR2;
			end
			PH_HDR2: begin
				frame_left = '0;
				if (b[6:0] == LEN_EXT64) begin
					ext_left = EXT64_BYTES;
					rx_phase = PH_EXT;
				end else if (b[6:0] == LEN_EXT16) begin
					ext_left = EXT16_BYTES;
					rx_phase = PH_EXT;
				end else begin
					frame_left = {57'd0, b[6:0]};
					close_header();
				end
			end
			PH_EXT: begin
				frame_left = {frame_left[55:0], b};
				if (ext_left != 0)
					ext_left--;
				if (ext_left == 0)
					close_header();
			end
			default: begin
				frame_left--;
				expect_word(b, 1'b1, frame_left == 0 && frame_fin);
				if (frame_left == 0) begin
					rx_phase = PH_HDR1;
					if (frame_fin)
						end_message();
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	// driver: present the next word on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !word_taken) begin
				// hold the word until it is taken
			end else if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left--;
			end else if (rx_bytes.size() != 0 &&
					!(rx_bytes[0].hold_off && payload_due.size() != 0)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rx_bytes[0].data;
				rx_bytes.pop_front();
				gap_left = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			word_taken = 1'b0;
		end
	end

	// sink: stall the output side at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// monitor: predict on each accepted byte, check each output word
	always @(posedge clk) begin : monitor
		result_t want;
		cycles++;
		if (cycles % 400 == 0)
			quiet = ($urandom_range(0, 3) == 0);
		if (cycles >= CYCLE_LIMIT) begin
			$display("websocket_frame_deframer_unit: mismatch");
			$finish;
		end else if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata);
				word_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (payload_due.size() == 0) begin
					errors++;
					$display("%0t ns: word expected none, actual data %h user %h last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = payload_due.pop_front();
					check_field("payload_byte", 64'(want.payload_byte), 64'(m_axis_tdata[7:0]));
					check_field("has_byte", 64'(want.has_byte), 64'(m_axis_tuser[0]));
					check_field("message_last", 64'(want.message_last), 64'(m_axis_tlast));
					check_field("message_opcode", 64'(want.message_opcode),
						64'(m_axis_tuser[4:1]));
					check_field("message_length", want.message_length, m_axis_tdata[71:8]);
				end
			end
		end
	end

	initial begin : stimulus
		int nfr;
		int sel;
		int msg;
		int kind;
		int flen;
		bit broken;
		bit fin;
		logic [3:0] opc;
		logic [2:0] rsv;

		// directed frames
		add_frame(1'b1, 4'h1, 3'b000, 1'b0, 0, 64'd0, 0, 1'b0);   // empty final frame
		add_frame(1'b0, 4'h2, 3'b000, 1'b1, 0, 64'd0, 0, 1'b0);   // empty non-final frame
		add_frame(1'b1, 4'h0, 3'b000, 1'b0, 0, 64'd1, 1, 1'b0);   // opcode kept from first
		add_frame(1'b1, 4'h9, 3'b111, 1'b1, 1, 64'd3, 3, 1'b0);   // control opcode, RSV set
		add_frame(1'b1, 4'hF, 3'b000, 1'b0, 2, 64'd2, 2, 1'b0);
		add_frame(1'b1, 4'hA, 3'b000, 1'b0, 1, 64'd0, 0, 1'b0);   // extended, zero length

		// random messages, mostly well formed
		msg = 0;
		while (rx_bytes.size() < 880) begin
			nfr = $urandom_range(1, 3);
			broken = ($urandom_range(0, 19) == 0);
			for (int f = 0; f < nfr; f++) begin
				fin = (f == nfr - 1) && !broken;
				if (f == 0)
					opc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 2));
				else
					opc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
				rsv = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
				sel = $urandom_range(0, 19);
				if (sel < 12) begin
					kind = 0;
					flen = $urandom_range(0, 20);
				end else if (sel < 14) begin
					kind = 0;
					flen = $urandom_range(0, 125);
				end else if (sel < 17) begin
					kind = 1;
					flen = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
						: $urandom_range(0, 40);
				end else begin
					kind = 2;
					flen = $urandom_range(0, 40);
				end
				add_frame(fin, opc, rsv, 1'($urandom_range(0, 1)), kind, 64'(flen), flen,
					f == 0 && msg % 25 == 0);
			end
			msg++;
		end

		// saturating length: short frame, then a huge frame sent in part
		add_frame(1'b0, 4'h1, 3'b000, 1'b0, 0, 64'd3, 3, 1'b1);
		add_frame(1'b1, 4'h0, 3'b000, 1'b1, 2, 64'hFFFF_FFFF_FFFF_FFFE, 6, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (rx_bytes.size() != 0 || s_axis_tvalid);
		while (payload_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("websocket_frame_deframer_unit: match");
		else
			$display("websocket_frame_deframer_unit: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/wsfd_pkg.sv
rtl/core/wsfd_parser.sv
rtl/core/wsfd_queue.sv
rtl/core/wsfd_out.sv
rtl/core/websocket_frame_deframer_unit.sv
tb/tb_websocket_frame_deframer_unit.sv
